// ----- sv/jsu_pkg.sv -----
package jsu_pkg;

    // Decoder modes, one per position in the string grammar
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_BODY    = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX1    = 3'd3,
        MODE_PAIR_BS = 3'd4,
        MODE_PAIR_U  = 3'd5,
        MODE_HEX2    = 3'd6,
        MODE_DRAIN   = 3'd7
    } mode_t;

    // Result kinds as they appear on out_kind
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Data carried by one queue entry
    typedef enum logic [1:0] {
        DATA_NONE = 2'd0,
        DATA_RAW  = 2'd1,
        DATA_CP   = 2'd2
    } data_t;

    // One queue entry: all results caused by one input beat
    typedef struct packed {
        data_t       data;
        logic [31:0] cp;       // code point, or raw byte in [7:0]
        logic        term_en;  // a close or error result follows the data
        kind_t       term;
    } rec_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [31:0] SURR_HI_MIN = 32'h0000_D800;
    localparam logic [15:0] SURR_HI_LO  = 16'hD800;
    localparam logic [15:0] SURR_HI_HI  = 16'hDBFF;
    localparam logic [31:0] SURR_LO_MIN = 32'h0000_DC00;
    localparam logic [31:0] PLANE1      = 32'h0001_0000;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] e);
        logic [7:0] r;
        unique case (e)
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = e;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [31:0] cp);
        logic [2:0] n;
        if (cp < 32'h80) n = 3'd1;
        else if (cp < 32'h800) n = 3'd2;
        else if (cp < PLANE1) n = 3'd3;
        else n = 3'd4;
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [1:0] idx);
        logic [2:0] n;
        logic [7:0] r;
        n = utf8_len(cp);
        r = 8'h00;
        unique case (n)
            3'd1: r = cp[7:0];
            3'd2: begin
                unique case (idx)
                    2'd0:    r = 8'hC0 | cp[13:6];
                    default: r = 8'h80 | {2'b00, cp[5:0]};
                endcase
            end
            3'd3: begin
                unique case (idx)
                    2'd0:    r = 8'hE0 | cp[19:12];
                    2'd1:    r = 8'h80 | {2'b00, cp[11:6]};
                    default: r = 8'h80 | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    r = 8'hF0 | cp[25:18];
                    2'd1:    r = 8'h80 | {2'b00, cp[17:12]};
                    2'd2:    r = 8'h80 | {2'b00, cp[11:6]};
                    default: r = 8'h80 | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ----- sv/jsu_front.sv -----
module jsu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             source_end,
    input  logic             q_full,
    output logic             q_push,
    output jsu_pkg::rec_t    q_rec
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     dc_reg, dc_next;
    logic [15:0]    hi_reg, hi_next;
    logic [15:0]    lo_reg, lo_next;

    logic           accept;
    logic [4:0]     hexv;
    logic [15:0]    hi_shift;
    logic [15:0]    lo_shift;
    logic [31:0]    cp_pair;

    // classification of the current beat
    logic           closed;
    logic           bad;
    logic           fail;
    jsu_pkg::data_t data_kind;
    logic [31:0]    data_cp;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign hexv     = jsu_pkg::hex_value(in_byte);
    assign hi_shift = {hi_reg[11:0], hexv[3:0]};
    assign lo_shift = {lo_reg[11:0], hexv[3:0]};
    // wraps in 32 bits; low half is not range checked
    assign cp_pair  = jsu_pkg::PLANE1
                    + (({16'h0000, hi_reg} - jsu_pkg::SURR_HI_MIN) << 10)
                    + ({16'h0000, lo_shift} - jsu_pkg::SURR_LO_MIN);

    always_comb
    begin
        closed    = 1'b0;
        bad       = 1'b0;
        data_kind = jsu_pkg::DATA_NONE;
        data_cp   = 32'h0;
        unique case (mode_reg)
            jsu_pkg::MODE_IDLE: begin
                bad = (in_byte != jsu_pkg::CH_QUOTE) && !jsu_pkg::is_ws(in_byte);
            end
            jsu_pkg::MODE_BODY: begin
                if (in_byte == jsu_pkg::CH_QUOTE) begin
                    closed = 1'b1;
                end
                else if (in_byte != jsu_pkg::CH_BSL) begin
                    data_kind = jsu_pkg::DATA_RAW;
                    data_cp   = {24'h0, in_byte};
                end
            end
            jsu_pkg::MODE_ESC: begin
                if (in_byte != jsu_pkg::CH_U) begin
                    data_kind = jsu_pkg::DATA_RAW;
                    data_cp   = {24'h0, jsu_pkg::map_escape(in_byte)};
                end
            end
            jsu_pkg::MODE_HEX1: begin
                bad = !hexv[4];
                if (hexv[4] && dc_reg == 2'd3
                    && !(hi_shift >= jsu_pkg::SURR_HI_LO && hi_shift <= jsu_pkg::SURR_HI_HI)) begin
                    data_kind = jsu_pkg::DATA_CP;
                    data_cp   = {16'h0, hi_shift};
                end
            end
            jsu_pkg::MODE_PAIR_BS: begin
                bad = (in_byte != jsu_pkg::CH_BSL);
            end
            jsu_pkg::MODE_PAIR_U: begin
                bad = (in_byte != jsu_pkg::CH_U);
            end
            jsu_pkg::MODE_HEX2: begin
                bad = !hexv[4];
                if (hexv[4] && dc_reg == 2'd3) begin
                    data_kind = jsu_pkg::DATA_CP;
                    data_cp   = cp_pair;
                end
            end
            jsu_pkg::MODE_DRAIN: begin
                bad = 1'b0;
            end
        endcase
    end

    assign fail = (mode_reg != jsu_pkg::MODE_DRAIN) && (bad || (!closed && source_end));

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        dc_next   = dc_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (accept) begin
            unique case (mode_reg)
                jsu_pkg::MODE_IDLE: begin
                    if (in_byte == jsu_pkg::CH_QUOTE) mode_next = jsu_pkg::MODE_BODY;
                end
                jsu_pkg::MODE_BODY: begin
                    if (in_byte == jsu_pkg::CH_BSL) mode_next = jsu_pkg::MODE_ESC;
                end
                jsu_pkg::MODE_ESC: begin
                    if (in_byte == jsu_pkg::CH_U) begin
                        mode_next = jsu_pkg::MODE_HEX1;
                        dc_next   = 2'd0;
                        hi_next   = 16'h0;
                    end
                    else begin
                        mode_next = jsu_pkg::MODE_BODY;
                    end
                end
                jsu_pkg::MODE_HEX1: begin
                    if (hexv[4]) begin
                        hi_next = hi_shift;
                        if (dc_reg == 2'd3) begin
                            dc_next = 2'd0;
                            if (hi_shift >= jsu_pkg::SURR_HI_LO
                                && hi_shift <= jsu_pkg::SURR_HI_HI) begin
                                mode_next = jsu_pkg::MODE_PAIR_BS;
                            end
                            else begin
                                mode_next = jsu_pkg::MODE_BODY;
                            end
                        end
                        else begin
                            dc_next = 2'(dc_reg + 2'd1);
                        end
                    end
                end
                jsu_pkg::MODE_PAIR_BS: begin
                    mode_next = jsu_pkg::MODE_PAIR_U;
                end
                jsu_pkg::MODE_PAIR_U: begin
                    mode_next = jsu_pkg::MODE_HEX2;
                    dc_next   = 2'd0;
                    lo_next   = 16'h0;
                end
                jsu_pkg::MODE_HEX2: begin
                    if (hexv[4]) begin
                        lo_next = lo_shift;
                        if (dc_reg == 2'd3) begin
                            dc_next   = 2'd0;
                            mode_next = jsu_pkg::MODE_BODY;
                        end
                        else begin
                            dc_next = 2'(dc_reg + 2'd1);
                        end
                    end
                end
                jsu_pkg::MODE_DRAIN: begin
                    if (source_end) mode_next = jsu_pkg::MODE_IDLE;
                end
            endcase
            // a failure or a close overrides the transitions above
            if (fail) begin
                mode_next = source_end ? jsu_pkg::MODE_IDLE : jsu_pkg::MODE_DRAIN;
                dc_next   = 2'd0;
            end
            else if (closed) begin
                mode_next = jsu_pkg::MODE_IDLE;
            end
        end
    end

    // outputs towards the queue
    always_comb
    begin
        q_rec.data    = data_kind;
        q_rec.cp      = data_cp;
        q_rec.term_en = fail || closed;
        q_rec.term    = fail ? jsu_pkg::KIND_ERROR : jsu_pkg::KIND_CLOSE;
        q_push        = accept && (fail || closed || (data_kind != jsu_pkg::DATA_NONE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= jsu_pkg::MODE_IDLE;
            dc_reg   <= 2'd0;
            hi_reg   <= 16'h0;
            lo_reg   <= 16'h0;
        end
        else begin
            mode_reg <= mode_next;
            dc_reg   <= dc_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
        end
    end

endmodule

// ----- sv/jsu_fifo.sv -----
module jsu_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::rec_t push_rec,
    input  logic          pop,
    output jsu_pkg::rec_t head_rec,
    output logic          empty,
    output logic          full
);

    jsu_pkg::rec_t                  entry_reg [jsu_pkg::FIFO_DEPTH];
    logic [jsu_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [jsu_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [jsu_pkg::FIFO_AW:0]      count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (jsu_pkg::FIFO_AW+1)'(jsu_pkg::FIFO_DEPTH));
    assign head_rec = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? jsu_pkg::FIFO_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? jsu_pkg::FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = (jsu_pkg::FIFO_AW+1)'(count_reg + 1'b1);
        else if (pop && !push) count_next = (jsu_pkg::FIFO_AW+1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/jsu_back.sv -----
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  jsu_pkg::rec_t head_rec,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_kind,
    output logic [7:0]    out_byte,
    output logic          run_last
);

    logic                 out_valid_reg, out_valid_next;
    jsu_pkg::kind_t       kind_reg, kind_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [2:0]           pos_reg, pos_next;

    logic                 load;
    logic [2:0]           n_data;
    logic [2:0]           n_total;
    logic                 is_last;

    // one result leaves the head entry for each load
    assign load = !q_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        unique case (head_rec.data)
            jsu_pkg::DATA_RAW: n_data = 3'd1;
            jsu_pkg::DATA_CP:  n_data = jsu_pkg::utf8_len(head_rec.cp);
            default:           n_data = 3'd0;
        endcase
        n_total = 3'(n_data + {2'b00, head_rec.term_en});
        is_last = (pos_reg == 3'(n_total - 3'd1));
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        q_pop          = 1'b0;
        if (load) begin
            out_valid_next = 1'b1;
            last_next      = is_last;
            if (pos_reg < n_data) begin
                kind_next = jsu_pkg::KIND_BYTE;
                byte_next = (head_rec.data == jsu_pkg::DATA_RAW)
                          ? head_rec.cp[7:0]
                          : jsu_pkg::utf8_byte(head_rec.cp, pos_reg[1:0]);
            end
            else begin
                kind_next = head_rec.term;
                byte_next = 8'h00;
            end
            if (is_last) begin
                q_pop    = 1'b1;
                pos_next = 3'd0;
            end
            else begin
                pos_next = 3'(pos_reg + 3'd1);
            end
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign run_last  = last_reg;

endmodule

// ----- sv/json_string_unescape_utf8.sv -----
// JSON string decoder with UTF-8 output.
// Input channel (in_valid/in_ready): one source byte per beat, in_byte plus
// source_end, which marks the last byte of the source.
// Output channel (out_valid/out_ready): one result per beat. out_kind is a
// decoded byte, a close of the string, or an error; out_byte is zero unless
// a byte is carried; run_last marks the last result due to one input beat.
// An input beat gives 0 to 5 results (up to four UTF-8 bytes plus a close or
// error).
// Throughput: one input beat per cycle, limited by the output side at one
// result per cycle. The first result of a beat is registered in the queue
// and then in the output register before it is shown.
// Structure: the front decoder runs the grammar at one byte per cycle while
// in_ready is high and pushes one entry per productive beat into a 4-entry
// queue; the back end expands each entry into its results, one per cycle
// while the receiver accepts, into the output register. in_ready falls only when the queue is full.
// Reset puts the decoder in idle, awaiting whitespace or an opening quote,
// and empties queue and output register.
// A stalled receiver holds the output register; the queue then absorbs up to
// four productive beats before in_ready drops.
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       source_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       run_last
);

    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    jsu_pkg::rec_t push_rec;
    jsu_pkg::rec_t head_rec;

    // grammar and code point assembly
    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .source_end (source_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_rec      (push_rec)
    );

    // decouples decoding from result delivery
    jsu_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    // UTF-8 expansion and output register
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_rec  (head_rec),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue underflow");

    // close and error results carry no byte and end their run
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != jsu_pkg::KIND_BYTE) |-> (out_byte == 8'h00 && run_last))
        else $error("terminal result malformed");

    // an empty queue with no push and a ready receiver means nothing is shown next cycle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty && !q_push && out_ready) |=> !out_valid)
        else $error("spurious result");

endmodule
